### hw/rtl/rgb_hue_rotate_via_hsv_unit_assert.svh
// assertion macros shared by the hue rotation rtl
// clocked on clk, disabled while rst_n is low
`ifndef RGB_HUE_ROTATE_VIA_HSV_UNIT_ASSERT_SVH
`define RGB_HUE_ROTATE_VIA_HSV_UNIT_ASSERT_SVH

// condition holds at every edge
`define HROT_CHECK(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hrot check failed");

// antecedent implies consequent at the same edge
`define HROT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrot implication failed");

`endif

### hw/rtl/hrot_pkg.sv
// ----------------------------------------------------------------------------
// hrot_pkg
// shared types and constants of the hsv hue rotation pipeline
// ----------------------------------------------------------------------------
package hrot_pkg;

    // hue is a q0.16 fraction of a turn
    localparam int FRAC_BITS = 16;
    // restoring divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS = 2;
    localparam int DIV_STAGES = FRAC_BITS / DIV_STEPS;
    // width of six times delta
    localparam int SIX_W = 11;

    // register map
    localparam logic [2:0] ADDR_HUE_OFFSET = 3'd0;

    // sextants of the hue circle
    typedef enum logic [2:0] {
        SEXT_0 = 3'd0,
        SEXT_1 = 3'd1,
        SEXT_2 = 3'd2,
        SEXT_3 = 3'd3,
        SEXT_4 = 3'd4,
        SEXT_5 = 3'd5
    } sext_t;

    // pixel context carried down the pipe
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] mx;
        logic [7:0] mn;
        logic       grey;
    } pix_t;

    // word leaving the divider
    typedef struct packed {
        pix_t                 pix;
        logic [FRAC_BITS-1:0] hue;
    } hue_word_t;

endpackage

### hw/rtl/hrot_cfg.sv
// ----------------------------------------------------------------------------
// hrot_cfg
// apb register file holding the hue offset
// ----------------------------------------------------------------------------
module hrot_cfg
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [16:0] hue_shift
);

    logic [16:0] offset_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == hrot_pkg::ADDR_HUE_OFFSET);

    // offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (wr_en)
        begin
            offset_reg <= pwdata[16:0];
        end
    end

    // read back, sign extended
    always_comb
    begin
        if (paddr == hrot_pkg::ADDR_HUE_OFFSET)
        begin
            prdata = {{15{offset_reg[16]}}, offset_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign hue_shift = offset_reg;

endmodule

### hw/rtl/hrot_div.sv
// ----------------------------------------------------------------------------
// hrot_div
// pipelined restoring divider giving hue = num * 2^16 / (6 * delta)
// ----------------------------------------------------------------------------
`include "rgb_hue_rotate_via_hsv_unit_assert.svh"

module hrot_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  hrot_pkg::pix_t                       in_pix,
    input  logic [hrot_pkg::SIX_W-1:0]           in_num,
    input  logic [hrot_pkg::SIX_W-1:0]           in_six,
    output logic                                 out_valid,
    output hrot_pkg::hue_word_t                  out_word
);

    localparam int N = hrot_pkg::DIV_STAGES;
    localparam int W = hrot_pkg::SIX_W;
    localparam int F = hrot_pkg::FRAC_BITS;
    localparam int S = hrot_pkg::DIV_STEPS;

    logic                 valid_reg [N+1];
    hrot_pkg::pix_t       pix_reg   [N+1];
    logic [W-1:0]         rem_reg   [N+1];
    logic [W-1:0]         six_reg   [N+1];
    logic [F-1:0]         quo_reg   [N+1];

    // stage zero is the input word
    always_comb
    begin
        valid_reg[0] = in_valid;
        pix_reg[0]   = in_pix;
        rem_reg[0]   = in_num;
        six_reg[0]   = in_six;
        quo_reg[0]   = '0;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [W-1:0] rem_next;
        logic [F-1:0] quo_next;

        // DIV_STEPS quotient bits per stage
        always_comb
        begin
            logic [W:0] shifted;
            rem_next = rem_reg[k];
            quo_next = quo_reg[k];
            for (int s = 0; s < S; s++)
            begin
                shifted = {rem_next, 1'b0};
                if (shifted >= {1'b0, six_reg[k]})
                begin
                    shifted  = shifted - {1'b0, six_reg[k]};
                    quo_next = {quo_next[F-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[F-2:0], 1'b0};
                end
                rem_next = shifted[W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pix_reg[k+1] <= pix_reg[k];
                rem_reg[k+1] <= rem_next;
                six_reg[k+1] <= six_reg[k];
                quo_reg[k+1] <= quo_next;
            end
        end
    end

    assign out_valid    = valid_reg[N];
    assign out_word.pix = pix_reg[N];
    assign out_word.hue = quo_reg[N];

    // remainder stays below the divisor for colour pixels
    `HROT_IMPLY(a_rem_bound, valid_reg[N] && !pix_reg[N].grey, rem_reg[N] < six_reg[N])
    `HROT_IMPLY(a_num_bound, in_valid && !in_pix.grey, in_num < in_six)

endmodule

### hw/rtl/hrot_back.sv
// ----------------------------------------------------------------------------
// hrot_back
// adds the offset, splits hue into sextant and fraction, rebuilds rgb
// ----------------------------------------------------------------------------
`include "rgb_hue_rotate_via_hsv_unit_assert.svh"

module hrot_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [16:0]           hue_shift,
    input  logic                  in_valid,
    input  hrot_pkg::hue_word_t   in_word,
    output logic                  out_valid,
    output logic [23:0]           out_data
);

    localparam int F = hrot_pkg::FRAC_BITS;

    // stage a: offset and sextant split
    logic              a_valid_reg;
    hrot_pkg::pix_t    a_pix_reg;
    hrot_pkg::sext_t   a_sext_reg;
    logic [F-1:0]      a_frac_reg;
    logic [7:0]        a_delta_reg;
    logic [F-1:0]      sum_next;
    logic [F+2:0]      h6_next;

    assign sum_next = in_word.hue + hue_shift[F-1:0];
    assign h6_next  = {1'b0, sum_next, 2'b00} + {2'b00, sum_next, 1'b0};

    // stage b: delta times fraction
    logic              b_valid_reg;
    hrot_pkg::pix_t    b_pix_reg;
    hrot_pkg::sext_t   b_sext_reg;
    logic [F+7:0]      b_prod_reg;

    // stage c: output word
    logic              c_valid_reg;
    logic [23:0]       c_data_reg;
    logic [7:0]        frac_t;
    logic [7:0]        frac_q;
    logic [7:0]        tt;
    logic [7:0]        qq;
    logic [23:0]       data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pix_reg   <= in_word.pix;
            a_sext_reg  <= hrot_pkg::sext_t'(h6_next[F+2:F]);
            a_frac_reg  <= h6_next[F-1:0];
            a_delta_reg <= in_word.pix.mx - in_word.pix.mn;
            b_pix_reg   <= a_pix_reg;
            b_sext_reg  <= a_sext_reg;
            b_prod_reg  <= a_delta_reg * a_frac_reg;
            c_data_reg  <= data_next;
        end
    end

    // t rounds down, q rounds the subtracted part up
    assign frac_t = b_prod_reg[F+7:F];
    assign frac_q = frac_t + {7'd0, |b_prod_reg[F-1:0]};
    assign tt     = b_pix_reg.mn + frac_t;
    assign qq     = b_pix_reg.mx - frac_q;

    // six-sextant rebuild, grey passes through
    always_comb
    begin
        if (b_pix_reg.grey)
        begin
            data_next = {b_pix_reg.b, b_pix_reg.g, b_pix_reg.r};
        end
        else
        begin
            unique case (b_sext_reg)
                hrot_pkg::SEXT_0: data_next = {b_pix_reg.mn, tt, b_pix_reg.mx};
                hrot_pkg::SEXT_1: data_next = {b_pix_reg.mn, b_pix_reg.mx, qq};
                hrot_pkg::SEXT_2: data_next = {tt, b_pix_reg.mx, b_pix_reg.mn};
                hrot_pkg::SEXT_3: data_next = {b_pix_reg.mx, qq, b_pix_reg.mn};
                hrot_pkg::SEXT_4: data_next = {b_pix_reg.mx, b_pix_reg.mn, tt};
                default:          data_next = {qq, b_pix_reg.mn, b_pix_reg.mx};
            endcase
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

    `HROT_IMPLY(a_sext_range, a_valid_reg, a_sext_reg <= hrot_pkg::SEXT_5)
    `HROT_IMPLY(a_frac_bound, b_valid_reg && !b_pix_reg.grey,
                frac_q <= (b_pix_reg.mx - b_pix_reg.mn))

endmodule

### hw/rtl/rgb_hue_rotate_via_hsv_unit.sv
// 1 front, 8 divider, 3 back stages; restoring divider: 2 quotient bits per stage
// throughput: one pixel per clock except while the output is stalled
// a stall on the output holds every stage at once, nothing is lost or repeated
// reset: rst_n clears all valid bits and sets the hue shift register to zero
// ----------------------------------------------------------------------------
// rgb_hue_rotate_via_hsv_unit
// rotates the hue of an 8-bit rgb pixel stream by a programmable offset
// ----------------------------------------------------------------------------
module rgb_hue_rotate_via_hsv_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out, green_out, blue_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W = hrot_pkg::SIX_W;

    logic                 en;
    logic [16:0]          hue_shift;
    logic [7:0]           r, g, b, mx, mn, delta;
    logic [W:0]           six_w, num_w;
    hrot_pkg::pix_t       pix_next;

    logic                 f_valid_reg;
    hrot_pkg::pix_t       f_pix_reg;
    logic [W-1:0]         f_num_reg;
    logic [W-1:0]         f_six_reg;

    logic                 d_valid;
    hrot_pkg::hue_word_t  d_word;

    // whole pipe advances unless the output word is stalled
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    hrot_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .hue_shift  (hue_shift)
    );

    // front: max, min and sextant numerator
    assign r = s_tdata[7:0];
    assign g = s_tdata[15:8];
    assign b = s_tdata[23:16];

    always_comb
    begin
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        six_w = {2'b00, delta, 2'b00} + {3'b000, delta, 1'b0};
        priority if (r == mx)
        begin
            if (g >= b)
                num_w = {4'd0, g} - {4'd0, b};
            else
                num_w = six_w + {4'd0, g} - {4'd0, b};
        end
        else if (g == mx)
        begin
            num_w = {3'd0, delta, 1'b0} + {4'd0, b} - {4'd0, r};
        end
        else
        begin
            num_w = {2'd0, delta, 2'b00} + {4'd0, r} - {4'd0, g};
        end
        pix_next.r    = r;
        pix_next.g    = g;
        pix_next.b    = b;
        pix_next.mx   = mx;
        pix_next.mn   = mn;
        pix_next.grey = (mx == mn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_pix_reg <= pix_next;
            f_num_reg <= num_w[W-1:0];
            f_six_reg <= six_w[W-1:0];
        end
    end

    hrot_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid_reg),
        .in_pix    (f_pix_reg),
        .in_num    (f_num_reg),
        .in_six    (f_six_reg),
        .out_valid (d_valid),
        .out_word  (d_word)
    );

    hrot_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .hue_shift  (hue_shift),
        .in_valid   (d_valid),
        .in_word    (d_word),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata)
    );

endmodule

### verif/tb_rgb_hue_rotate_via_hsv_unit.sv
// ----------------------------------------------------------------------------
// tb_rgb_hue_rotate_via_hsv_unit
// self-checking bench for the hsv hue rotation unit: a fixed-point predictor
// computes each rotated pixel, a directed table then random pixels under
// several offsets and idling phases are compared word by word
// ----------------------------------------------------------------------------
module tb_rgb_hue_rotate_via_hsv_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;
    localparam int DRAIN = 40;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } rgb_t;

    typedef struct {
        rgb_t pix;
        logic chk;
        rgb_t res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rgb_t        rotated_q[$];
    logic signed [16:0] offset_shadow = '0;
    int          src_idle = 0;
    int          snk_stall = 0;
    int          mismatches = 0;
    int          words_checked = 0;
    int          cycles = 0;

    rgb_hue_rotate_via_hsv_unit u_dut (.*);

    always #5 clk = ~clk;

    // rotate one pixel by the shadow offset
    function automatic rgb_t rotate_pixel(rgb_t p);
        int unsigned mx, mn, dl, six, num, hue, sum, h6, sx, f, ft, fq;
        int unsigned vv, pp, tt, qq;
        rgb_t o;
        mx = p.r; mn = p.r;
        if (p.g > mx) mx = p.g;
        if (p.b > mx) mx = p.b;
        if (p.g < mn) mn = p.g;
        if (p.b < mn) mn = p.b;
        if (mx == mn) return p;
        dl = mx - mn;
        six = 6 * dl;
        if (p.r == mx) num = six + p.g - p.b;
        else if (p.g == mx) num = 2 * dl + p.b - p.r;
        else num = 4 * dl + p.r - p.g;
        if (num >= six) num -= six;
        hue = (num << 16) / six;
        sum = (hue + int'(offset_shadow)) & 32'hffff;
        h6 = sum * 6;
        sx = h6 >> 16;
        f = h6 & 32'hffff;
        ft = (dl * f) >> 16;
        fq = (dl * f + 32'hffff) >> 16;
        vv = mx; pp = mn; tt = mn + ft; qq = mx - fq;
        case (hrot_pkg::sext_t'(sx))
            hrot_pkg::SEXT_0: begin o.r = 8'(vv); o.g = 8'(tt); o.b = 8'(pp); end
            hrot_pkg::SEXT_1: begin o.r = 8'(qq); o.g = 8'(vv); o.b = 8'(pp); end
            hrot_pkg::SEXT_2: begin o.r = 8'(pp); o.g = 8'(vv); o.b = 8'(tt); end
            hrot_pkg::SEXT_3: begin o.r = 8'(pp); o.g = 8'(qq); o.b = 8'(vv); end
            hrot_pkg::SEXT_4: begin o.r = 8'(tt); o.g = 8'(pp); o.b = 8'(vv); end
            default:          begin o.r = 8'(vv); o.g = 8'(pp); o.b = 8'(qq); end
        endcase
        return o;
    endfunction

    function automatic void report(string what, rgb_t exp_w, rgb_t act_w);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected r%0d g%0d b%0d got r%0d g%0d b%0d", what,
                     exp_w.r, exp_w.g, exp_w.b, act_w.r, act_w.g, act_w.b);
    endfunction

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        rgb_t act_w;
        rgb_t exp_w;
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            act_w = m_tdata;
            if (rotated_q.size() == 0)
                report("unexpected word", '0, act_w);
            else
            begin
                exp_w = rotated_q.pop_front();
                words_checked++;
                if (act_w.r !== exp_w.r || act_w.g !== exp_w.g || act_w.b !== exp_w.b)
                    report("pixel", exp_w, act_w);
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall);
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("timeout with %0d words outstanding", rotated_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // register write, only while the pipe is empty
    task automatic write_offset(logic signed [16:0] value);
        s_tvalid <= 1'b0;
        wait (rotated_q.size() == 0);
        repeat (DRAIN) @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= hrot_pkg::ADDR_HUE_OFFSET;
        pwdata <= {{15{value[16]}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        offset_shadow = value;
    endtask

    // send one pixel, queue the prediction or a typed-in result
    task automatic send_pixel(rgb_t p, logic chk, rgb_t res);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        rotated_q.push_back(chk ? res : rotate_pixel(p));
    endtask

    // mostly random colours, sometimes grey, narrow delta or saturated
    function automatic rgb_t random_pixel();
        rgb_t p;
        p = 24'($urandom);
        case ($urandom_range(5))
            0: begin p.g = p.r; p.b = p.r; end
            1: begin p.g = p.r + 8'($urandom_range(2)); p.b = p.r; end
            2: begin p.r = 8'hff; p.b = 8'h00; end
            default: ;
        endcase
        return p;
    endfunction

    initial
    begin
        row_t dir_rows[$];
        logic signed [16:0] offsets[8];
        int phase_idle[4];
        int phase_stall[4];
        row_t rw;
        offsets = '{17'sd0, 17'sd65535, -17'sd65535, 17'sd21845, -17'sd1, 17'sd32768,
                    17'sd10923, -17'sd40000};
        phase_idle = '{0, 74, 0, 34};
        phase_stall = '{0, 0, 74, 34};

        // directed table: greys, black, white, primaries, ties
        dir_rows = '{
            '{'{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
            '{'{8'hff, 8'hff, 8'hff}, 1'b1, '{8'hff, 8'hff, 8'hff}},
            '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd128, 8'd128, 8'd128}},
            '{'{8'd0, 8'd0, 8'hff}, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{'{8'd0, 8'hff, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{'{8'hff, 8'd0, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{'{8'd0, 8'hff, 8'hff}, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{'{8'hff, 8'd0, 8'hff}, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{'{8'hff, 8'hff, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{'{8'd1, 8'd0, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{'{8'hff, 8'hfe, 8'hff}, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{'{8'h55, 8'haa, 8'h7f}, 1'b0, '{8'd0, 8'd0, 8'd0}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // each offset setting: directed table then random pixels
        foreach (offsets[k])
        begin
            write_offset(offsets[k]);
            src_idle = phase_idle[k % 4];
            snk_stall = phase_stall[k % 4];
            foreach (dir_rows[i])
            begin
                rw = dir_rows[i];
                send_pixel(rw.pix, rw.chk && (k == 0 || rw.pix.r == rw.pix.g), rw.res);
            end
            repeat (200)
                send_pixel(random_pixel(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        wait (rotated_q.size() == 0);
        repeat (DRAIN) @(posedge clk);
        $display("checked %0d rotated pixels over %0d offset settings and four idling mixes",
                 words_checked, 8);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
